// ===== sv/point_in_polygon_test_defines.svh =====
// Assertion helpers for the point-in-polygon test block.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// same-cycle implication
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

  localparam int NUM_VERTICES = 16;
  localparam int COORD_W      = 32;
  localparam int SLOT_W       = 4;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int VIDX_W       = $clog2(NUM_VERTICES);
  localparam int CNT_W        = $clog2(NUM_VERTICES + 2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [2*COORD_W-1:0]      vertex_t;

endpackage

`default_nettype wire

// ===== sv/point_in_polygon_test.sv =====
// Load transaction: vertex written at the accepting edge; ready again the next cycle.
// Test transaction: NUM_VERTICES+1 vertex reads from the single-port vertex memory
//   (one per cycle) followed by subtract, multiply and compare stages, after which
//   the result is registered on the output.
// One test at a time: in_ready is low from acceptance until the result is registered, longer while a result waits.
// Reset (rst_n, synchronous, active low) clears control only; vertex memory is undefined.
`default_nettype none

module point_in_polygon_test (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_op,
  input  wire  [pip_pkg::SLOT_W-1:0]    in_vertex_slot,
  input  wire  signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  wire  signed [pip_pkg::COORD_W-1:0] in_coord_y,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_inside_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam int VIDX_W = pip_pkg::VIDX_W;
  localparam int CNT_W  = pip_pkg::CNT_W;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  pip_pkg::coord_t  tx_r, ty_r;
  pip_pkg::vertex_t vmem [pip_pkg::NUM_VERTICES];
  pip_pkg::vertex_t rd_data_r;
  pip_pkg::coord_t  prev_x_r, prev_y_r;

  logic rd_vld_r, rd_first_r, rd_last_r;
  logic a_vld_r, a_last_r, a_straddle_r, a_dypos_r;
  logic m_vld_r, m_last_r, m_straddle_r, m_dypos_r;
  pip_pkg::diff_t a_lhs_r, a_dy_r, a_rhs_a_r, a_rhs_b_r;
  pip_pkg::prod_t p1_r, p2_r;

  logic flag_r, flag_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_res_r, out_res_nxt;

  logic             in_acc, test_acc, load_acc, issue, hit, done;
  logic [VIDX_W-1:0] rd_addr;
  pip_pkg::coord_t  xi, yi;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign test_acc       = in_acc && (in_op == pip_pkg::OP_TEST);
  assign load_acc       = in_acc && (in_op == pip_pkg::OP_LOAD);
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

  assign issue   = (state_r == ST_RUN) && (cnt_r <= CNT_W'(pip_pkg::NUM_VERTICES));
  assign rd_addr = (cnt_r == '0) ? VIDX_W'(pip_pkg::NUM_VERTICES - 1)
                                 : VIDX_W'(cnt_r - CNT_W'(1));

  // vertex memory
  always_ff @(posedge clk) begin
    if (load_acc && (32'(in_vertex_slot) < pip_pkg::NUM_VERTICES)) begin
      vmem[VIDX_W'(in_vertex_slot)] <= {in_coord_y, in_coord_x};
    end
    if (issue) begin
      rd_data_r <= vmem[rd_addr];
    end
  end

  assign xi = rd_data_r[pip_pkg::COORD_W-1:0];
  assign yi = rd_data_r[2*pip_pkg::COORD_W-1:pip_pkg::COORD_W];

  // datapath: differences, products
  always_ff @(posedge clk) begin
    if (test_acc) begin
      tx_r <= in_coord_x;
      ty_r <= in_coord_y;
    end
    if (rd_vld_r) begin
      prev_x_r     <= xi;
      prev_y_r     <= yi;
      a_straddle_r <= (yi > ty_r) != (prev_y_r > ty_r);
      a_dypos_r    <= prev_y_r > yi;
      a_dy_r       <= pip_pkg::DIFF_W'(prev_y_r) - pip_pkg::DIFF_W'(yi);
      a_lhs_r      <= pip_pkg::DIFF_W'(tx_r) - pip_pkg::DIFF_W'(xi);
      a_rhs_a_r    <= pip_pkg::DIFF_W'(prev_x_r) - pip_pkg::DIFF_W'(xi);
      a_rhs_b_r    <= pip_pkg::DIFF_W'(ty_r) - pip_pkg::DIFF_W'(yi);
    end
    if (a_vld_r) begin
      p1_r         <= a_lhs_r * a_dy_r;
      p2_r         <= a_rhs_a_r * a_rhs_b_r;
      m_straddle_r <= a_straddle_r;
      m_dypos_r    <= a_dypos_r;
    end
  end

  assign hit  = m_straddle_r && (m_dypos_r ? (p1_r < p2_r) : (p2_r < p1_r));
  assign done = m_vld_r && m_last_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (m_vld_r) begin
      flag_nxt = flag_r ^ hit;
    end
    if (issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (test_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          flag_nxt  = 1'b0;
        end
      end
      ST_RUN: begin
        if (done) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = flag_nxt;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      a_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      a_last_r    <= 1'b0;
      m_last_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= issue;
      rd_first_r  <= issue && (cnt_r == '0);
      rd_last_r   <= issue && (cnt_r == CNT_W'(pip_pkg::NUM_VERTICES));
      a_vld_r     <= rd_vld_r && !rd_first_r;
      a_last_r    <= rd_vld_r && rd_last_r;
      m_vld_r     <= a_vld_r;
      m_last_r    <= a_vld_r && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

`include "point_in_polygon_test_defines.svh"

  `PIP_ASSERT_NEXT(a_test_starts, test_acc, state_r == ST_RUN && cnt_r == '0, "test did not start walk")
  `PIP_ASSERT_NOW(a_hold_has_out, state_r == ST_HOLD, out_valid_r, "hold state without pending output")
  `PIP_ASSERT_NOW(a_read_in_run, rd_vld_r, state_r == ST_RUN, "vertex read outside a test")
  `PIP_ASSERT_NEXT(a_last_flows, a_vld_r && a_last_r, m_vld_r && m_last_r, "last edge lost in pipeline")

endmodule

`default_nettype wire

// ===== dv/point_in_polygon_test_scoreboard.sv =====
`timescale 1ns / 1ps

module point_in_polygon_test_scoreboard
  import pip_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire                in_op,
  input  wire  [SLOT_W-1:0]  in_vertex_slot,
  input  coord_t             in_coord_x,
  input  coord_t             in_coord_y,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire                out_inside_res,
  output int                 mismatch_count,
  output int                 expected_left,
  output int                 results_seen,
  output int                 inside_seen
);

  typedef struct {
    coord_t qx;
    coord_t qy;
    logic   in_poly;
  } query_rec_t;

  query_rec_t expected_q[$];
  coord_t     poly_x [NUM_VERTICES];
  coord_t     poly_y [NUM_VERTICES];

  // crossing parity over edges (k, k-1), starting with the closing edge
  function automatic logic predict_inside(input coord_t qx, input coord_t qy);
    logic   parity;
    logic   left;
    int     k;
    int     prev;
    coord_t xi, yi, xj, yj;
    diff_t  dy, dqx, dex, dqy;
    prod_t  p_left, p_right;
    parity = 1'b0;
    prev   = NUM_VERTICES - 1;
    for (k = 0; k < NUM_VERTICES; k++) begin
      xi = poly_x[k];
      yi = poly_y[k];
      xj = poly_x[prev];
      yj = poly_y[prev];
      if ((yi > qy) != (yj > qy)) begin
        dy      = diff_t'(yj) - diff_t'(yi);
        dqx     = diff_t'(qx) - diff_t'(xi);
        dex     = diff_t'(xj) - diff_t'(xi);
        dqy     = diff_t'(qy) - diff_t'(yi);
        p_left  = prod_t'(dqx) * prod_t'(dy);
        p_right = prod_t'(dex) * prod_t'(dqy);
        if (dy > 0) begin
          left = p_left < p_right;
        end else begin
          left = p_right < p_left;
        end
        if (left) begin
          parity = ~parity;
        end
      end
      prev = k;
    end
    return parity;
  endfunction

  initial begin
    mismatch_count = 0;
    expected_left  = 0;
    results_seen   = 0;
    inside_seen    = 0;
  end

  always @(posedge clk) begin : watch
    query_rec_t want;
    query_rec_t rec;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_inside_res === 1'b1) begin
          inside_seen++;
        end
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("[%0t] result inside=%b with no query outstanding", $time,
                     out_inside_res);
          end
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_inside_res !== want.in_poly) begin
            if (mismatch_count < 10) begin
              $display("[%0t] query (%h, %h): expected inside=%b, got %b", $time,
                       want.qx, want.qy, want.in_poly, out_inside_res);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_LOAD) begin
          if (in_vertex_slot < NUM_VERTICES) begin
            poly_x[in_vertex_slot] = in_coord_x;
            poly_y[in_vertex_slot] = in_coord_y;
          end
        end else begin
          rec.qx      = in_coord_x;
          rec.qy      = in_coord_y;
          rec.in_poly = predict_inside(in_coord_x, in_coord_y);
          expected_q.push_back(rec);
        end
      end
      expected_left = expected_q.size();
    end
  end

endmodule

// ===== dv/point_in_polygon_test_tb.sv =====
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
  import pip_pkg::*;

  localparam int     ITEM_TARGET = 1500;
  localparam int     CALM_AFTER  = 1300;
  localparam int     HOLD_AT     = 700;
  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_LIMIT = 2000;
  localparam coord_t C_MIN       = 32'sh8000_0000;
  localparam coord_t C_MAX       = 32'sh7FFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  logic [SLOT_W-1:0] in_vertex_slot;
  coord_t            in_coord_x;
  coord_t            in_coord_y;
  logic              out_valid;
  logic              out_ready;
  logic              out_inside_res;

  int mismatch_count;
  int expected_left;
  int results_seen;
  int inside_seen;

  logic   idle_on;
  logic   hold_req;
  int     sent;
  int     n_loads;
  int     n_tests;
  coord_t sh_x [NUM_VERTICES];
  coord_t sh_y [NUM_VERTICES];

  // concave outline: extremes, a repeated vertex, vertical and horizontal edges
  coord_t dir_vx [NUM_VERTICES] = '{
    C_MIN, 32'sh0, 32'sh0, C_MAX, C_MAX, 32'sh1, C_MAX, C_MAX,
    32'sh0001_0000, 32'sh0001_0000, 32'shFFFF_0000, 32'shFFFF_0000,
    C_MIN, C_MIN, 32'shF000_0000, C_MIN};
  coord_t dir_vy [NUM_VERTICES] = '{
    C_MIN, C_MIN, C_MIN, C_MIN, 32'shFFFF_FFFF, 32'sh0, 32'sh1, C_MAX,
    C_MAX, 32'sh4000_0000, 32'sh4000_0000, C_MAX,
    C_MAX, 32'sh0000_8000, 32'sh0, 32'shFFFF_8000};
  coord_t dir_qx [9] = '{
    32'sh0, C_MIN, C_MAX, C_MAX, 32'sh0, 32'sh0001_0000, C_MIN, 32'shFFFF_FFFF,
    32'sh7FFF_FFFE};
  coord_t dir_qy [9] = '{
    32'sh0, C_MIN, C_MAX, 32'sh0, 32'sh4000_0000, 32'sh5000_0000, 32'sh0,
    32'shFFFF_FFFF, 32'sh0};

  point_in_polygon_test i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_vertex_slot (in_vertex_slot),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

  point_in_polygon_test_scoreboard i_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_vertex_slot (in_vertex_slot),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left),
    .results_seen   (results_seen),
    .inside_seen    (inside_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d queries outstanding", expected_left);
    $display("** point_in_polygon_test: FAILED **");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin : result_sink
    logic hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic coord_t gen_coord(input int scale);
    case (scale)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(0, 524288)) - 262144);
      2:       return coord_t'(int'($urandom_range(0, 32)) - 16);
      default: begin
        case ($urandom_range(0, 4))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 32'sh0;
          3:       return 32'shFFFF_FFFF;
          default: return 32'sh1;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input coord_t x, input coord_t y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_vertex_slot <= slot;
    in_coord_x     <= x;
    in_coord_y     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_vertex(input logic [SLOT_W-1:0] slot, input coord_t x,
                             input coord_t y);
    send_item(OP_LOAD, slot, x, y);
    sh_x[slot] = x;
    sh_y[slot] = y;
    n_loads++;
  endtask

  task automatic query_point(input coord_t x, input coord_t y);
    send_item(OP_TEST, '0, x, y);
    n_tests++;
  endtask

  initial begin : stimulus
    int     k;
    int     n;
    int     pick;
    int     phase_scale;
    int     guard;
    coord_t qx, qy;
    sent    = 0;
    n_loads = 0;
    n_tests = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= OP_LOAD;
    in_vertex_slot <= '0;
    in_coord_x     <= '0;
    in_coord_y     <= '0;
    idle_on        <= 1'b1;
    hold_req       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_VERTICES; k++) begin
      load_vertex(SLOT_W'(k), dir_vx[k], dir_vy[k]);
    end
    for (k = 0; k < 9; k++) begin
      query_point(dir_qx[k], dir_qy[k]);
    end

    while (sent < ITEM_TARGET) begin
      if (sent >= CALM_AFTER) begin
        idle_on <= 1'b0;
      end
      if (sent >= HOLD_AT) begin
        hold_req <= 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 1)) begin
            load_vertex(SLOT_W'($urandom_range(0, NUM_VERTICES - 1)), coord_t'($urandom),
                        coord_t'($urandom));
          end else begin
            query_point(coord_t'($urandom), coord_t'($urandom));
          end
        end
      end else begin
        phase_scale = $urandom_range(0, 3);
        n = (pick <= 3) ? NUM_VERTICES : $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          load_vertex(SLOT_W'((n == NUM_VERTICES) ? k
                                                  : $urandom_range(0, NUM_VERTICES - 1)),
                      gen_coord(phase_scale), gen_coord(phase_scale));
        end
        repeat ($urandom_range(3, 12)) begin
          k = $urandom_range(0, NUM_VERTICES - 1);
          case ($urandom_range(0, 7))
            4: begin
              qx = gen_coord(phase_scale);
              qy = sh_y[k];
            end
            5: begin
              qx = sh_x[k];
              qy = sh_y[k];
            end
            6: begin
              n  = (k + NUM_VERTICES - 1) % NUM_VERTICES;
              qx = coord_t'((diff_t'(sh_x[k]) + diff_t'(sh_x[n])) >>> 1);
              qy = coord_t'((diff_t'(sh_y[k]) + diff_t'(sh_y[n])) >>> 1);
            end
            7: begin
              qx = coord_t'($urandom);
              qy = coord_t'($urandom);
            end
            default: begin
              qx = gen_coord(phase_scale);
              qy = gen_coord(phase_scale);
            end
          endcase
          query_point(qx, qy);
        end
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    while (expected_left != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);

    $display("Sent %0d vertex loads and %0d point queries; output held off %0d cycles once.",
             n_loads, n_tests, HOLD_CYCLES);
    $display("Compared %0d results (%0d inside), %0d mismatches, %0d never answered.",
             results_seen, inside_seen, mismatch_count, expected_left);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("** point_in_polygon_test: PASSED **");
    end else begin
      $display("** point_in_polygon_test: FAILED **");
    end
    $finish;
  end

endmodule
